// ----- src/knmh_pkg.sv -----
// ----------------------------------------------------------------------------
// knmh_pkg: shared types and constants of the k-nearest max-heap core
// Sizes of the heap, coordinates and identifiers, action codes and register
// indexes used by the core, its distance unit and its channel interfaces.
// ----------------------------------------------------------------------------
package knmh_pkg;

   localparam int HEAP_DEPTH  = 64;
   localparam int COORD_WIDTH = 16;
   localparam int ID_WIDTH    = 16;
   localparam int DIST_WIDTH  = 34;
   localparam int IDX_WIDTH   = $clog2(HEAP_DEPTH);
   localparam int CNT_WIDTH   = $clog2(HEAP_DEPTH + 1);
   localparam int KID_WIDTH   = IDX_WIDTH + 2;
   localparam int CSR_IDX_WIDTH = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [ID_WIDTH-1:0]           ident_type;
   typedef logic [DIST_WIDTH-1:0]         dist_type;
   typedef logic [IDX_WIDTH-1:0]          idx_type;
   typedef logic [CNT_WIDTH-1:0]          cnt_type;
   typedef logic [KID_WIDTH-1:0]          kid_type;
   typedef logic [1:0]                    action_type;
   typedef logic [CSR_IDX_WIDTH-1:0]      csr_idx_type;
   typedef logic [DIST_WIDTH-1:0]         csr_data_type;

   typedef struct packed {
      dist_type  distance;
      ident_type ident;
   } entry_type;

   localparam dist_type DIST_MAX    = '1;
   localparam cnt_type  DEPTH_COUNT = cnt_type'(HEAP_DEPTH);

   localparam action_type ACT_START = 2'd0;
   localparam action_type ACT_OFFER = 2'd1;
   localparam action_type ACT_READ  = 2'd2;

   localparam csr_idx_type CSR_QUERY_X   = 3'd0;
   localparam csr_idx_type CSR_QUERY_Y   = 3'd1;
   localparam csr_idx_type CSR_QUERY_Z   = 3'd2;
   localparam csr_idx_type CSR_RADIUS_SQ = 3'd3;
   localparam csr_idx_type CSR_WANTED    = 3'd4;

endpackage

// ----- src/knmh_if.sv -----
// ----------------------------------------------------------------------------
// knmh_if: request and response channels of the k-nearest max-heap core
// Valid/ready channels; an item moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface knmh_req_if;
   import knmh_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   coord_type  cand_x;
   coord_type  cand_y;
   coord_type  cand_z;
   ident_type  cand_id;
   idx_type    read_index;

   modport source (
      output valid, action, cand_x, cand_y, cand_z, cand_id, read_index,
      input  ready
   );
   modport sink (
      input  valid, action, cand_x, cand_y, cand_z, cand_id, read_index,
      output ready
   );
endinterface

interface knmh_rsp_if;
   import knmh_pkg::*;

   logic      valid;
   logic      ready;
   logic      accepted;
   cnt_type   found_count;
   dist_type  bound_distance;
   logic      entry_valid;
   ident_type entry_id;
   dist_type  entry_distance;

   modport source (
      output valid, accepted, found_count, bound_distance, entry_valid, entry_id,
             entry_distance,
      input  ready
   );
   modport sink (
      input  valid, accepted, found_count, bound_distance, entry_valid, entry_id,
             entry_distance,
      output ready
   );
endinterface

// ----- src/knmh_dist_unit.sv -----
// ----------------------------------------------------------------------------
// knmh_dist_unit: squared 3D distance over one shared multiplier
// Walks the three axes through a subtract, square and accumulate pipeline,
// then saturates the sum to the distance width. Result follows done.
// ----------------------------------------------------------------------------
module knmh_dist_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  knmh_pkg::coord_type cand_x,
   input  knmh_pkg::coord_type cand_y,
   input  knmh_pkg::coord_type cand_z,
   input  knmh_pkg::coord_type query_x,
   input  knmh_pkg::coord_type query_y,
   input  knmh_pkg::coord_type query_z,
   output logic                done,
   output knmh_pkg::dist_type  sq_dist
);
   import knmh_pkg::*;

   localparam int PROD_WIDTH = 2 * COORD_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int ACC_WIDTH  = (SUM_WIDTH > DIST_WIDTH) ? SUM_WIDTH : DIST_WIDTH + 1;
   localparam int STEP_WIDTH = 3;
   localparam logic [STEP_WIDTH-1:0] STEP_FIRST_ACC = 3'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_LAST      = 3'd4;

   logic                     busy_ff;
   logic                     done_ff;
   logic [STEP_WIDTH-1:0]    step_ff;
   coord_type                cx_ff, cy_ff, cz_ff;
   logic [COORD_WIDTH-1:0]   diff_ff;
   logic [PROD_WIDTH-1:0]    prod_ff;
   logic [ACC_WIDTH-1:0]     acc_ff;

   coord_type                cand_sel, query_sel;
   logic signed [COORD_WIDTH:0] diff_wide;
   logic [COORD_WIDTH:0]     abs_wide;
   logic [COORD_WIDTH-1:0]   diff_in;
   logic [PROD_WIDTH-1:0]    prod_in;

   always_comb begin
      case (step_ff[1:0])
         2'd0: begin
            cand_sel  = cx_ff;
            query_sel = query_x;
         end
         2'd1: begin
            cand_sel  = cy_ff;
            query_sel = query_y;
         end
         default: begin
            cand_sel  = cz_ff;
            query_sel = query_z;
         end
      endcase
      diff_wide = $signed({cand_sel[COORD_WIDTH-1], cand_sel})
                - $signed({query_sel[COORD_WIDTH-1], query_sel});
      abs_wide  = diff_wide[COORD_WIDTH] ? -diff_wide : diff_wide;
      // the magnitude never exceeds 2**COORD_WIDTH - 1
      diff_in   = abs_wide[COORD_WIDTH-1:0];
      prod_in   = diff_ff * diff_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == STEP_LAST);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
            end
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cx_ff  <= cand_x;
         cy_ff  <= cand_y;
         cz_ff  <= cand_z;
         acc_ff <= '0;
      end else if (busy_ff) begin
         diff_ff <= diff_in;
         prod_ff <= prod_in;
         if (step_ff >= STEP_FIRST_ACC) begin
            acc_ff <= acc_ff + ACC_WIDTH'(prod_ff);
         end
      end
   end

   assign done    = done_ff;
   assign sq_dist = (acc_ff > ACC_WIDTH'(DIST_MAX)) ? DIST_MAX : acc_ff[DIST_WIDTH-1:0];

endmodule

// ----- src/k_nearest_max_heap_core.sv -----
// ----------------------------------------------------------------------------
// k_nearest_max_heap_core: max-heap selection of the k nearest candidates
// Start clears the heap, offer computes the squared distance and inserts the
// candidate by sift-up or replaces the top by sift-down, read returns a slot.
// ----------------------------------------------------------------------------
//
//   channel    dir   handshake             contents
//   req_chan   in    valid / ready         action, candidate point and id, slot
//   rsp_chan   out   valid / ready         accepted, count, bound, slot entry
//   csr_*      in    csr_we, no wait       query point, radius, wanted count
//
// Start and unknown actions go from idle straight to emit, read goes through
// S_READ first. Offer runs the distance unit (one multiplier, three axes), then
// walks the sift path one heap level a cycle (one memory write and two reads a cycle).
// Reset is synchronous; the heap memory is not cleared, the fill count guards it.
// A result waits in the output register while the next item is accepted; the
// sequencer holds in its last step until that register is free.
//
module k_nearest_max_heap_core (
   input  logic                   clock,
   input  logic                   reset,
   knmh_req_if.sink               req_chan,
   knmh_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  knmh_pkg::csr_idx_type  csr_index,
   input  knmh_pkg::csr_data_type csr_wdata
);
   import knmh_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIST = 6'b000010,
      S_UP   = 6'b000100,
      S_DN   = 6'b001000,
      S_READ = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   coord_type query_x_ff, query_y_ff, query_z_ff;
   dist_type  radius_ff;
   cnt_type   wanted_ff;

   cnt_type   count_ff, count_in;
   dist_type  bound_ff, bound_in;
   logic      full_ff, full_in;
   idx_type   pos_ff, pos_in;
   entry_type cur_ff, cur_in;
   idx_type   read_idx_ff, read_idx_in;
   logic      acc_flag_ff, acc_flag_in;
   logic      entry_valid_ff, entry_valid_in;
   ident_type entry_id_ff, entry_id_in;
   dist_type  entry_dist_ff, entry_dist_in;
   dist_type  root_dist_ff;

   entry_type heap_mem [HEAP_DEPTH];
   entry_type rd_a_ff, rd_b_ff;
   logic      wr_en;
   idx_type   wr_addr;
   entry_type wr_data;
   idx_type   rd_a_addr, rd_b_addr;

   logic      rsp_valid_ff;
   logic      rsp_accepted_ff;
   cnt_type   rsp_count_ff;
   dist_type  rsp_bound_ff;
   logic      rsp_entry_valid_ff;
   ident_type rsp_entry_id_ff;
   dist_type  rsp_entry_dist_ff;
   logic      rsp_load;

   logic      dist_start;
   logic      dist_done;
   dist_type  dist_value;

   logic      ins_path;
   cnt_type   count_plus;
   cnt_type   want_eff;
   idx_type   parent_cnt, up_idx, up_up;
   kid_type   kid_l, kid_r, kid_sel;
   logic      has_l, has_r, dn_stop, dn_take_r;
   idx_type   child_idx, next_l;

   knmh_dist_unit u_dist (
      .clock   (clock),
      .reset   (reset),
      .start   (dist_start),
      .cand_x  (req_chan.cand_x),
      .cand_y  (req_chan.cand_y),
      .cand_z  (req_chan.cand_z),
      .query_x (query_x_ff),
      .query_y (query_y_ff),
      .query_z (query_z_ff),
      .done    (dist_done),
      .sq_dist (dist_value)
   );

   // heap addressing and sift decisions
   always_comb begin
      ins_path   = !full_ff && (count_ff < DEPTH_COUNT);
      count_plus = count_ff + 1'b1;
      if (wanted_ff == '0) begin
         want_eff = cnt_type'(1);
      end else if (wanted_ff > DEPTH_COUNT) begin
         want_eff = DEPTH_COUNT;
      end else begin
         want_eff = wanted_ff;
      end
      parent_cnt = (count_ff[IDX_WIDTH-1:0] - 1'b1) >> 1;
      up_idx     = (pos_ff - 1'b1) >> 1;
      up_up      = (up_idx - 1'b1) >> 1;

      kid_l = {1'b0, pos_ff, 1'b1};
      kid_r = kid_l + 1'b1;
      has_l = kid_l < KID_WIDTH'(count_ff);
      has_r = kid_r < KID_WIDTH'(count_ff);
      dn_stop   = 1'b0;
      dn_take_r = 1'b0;
      if (!has_l) begin
         dn_stop = 1'b1;
      end else if (rd_a_ff.distance <= cur_ff.distance) begin
         if (!has_r || (rd_b_ff.distance <= cur_ff.distance)) begin
            dn_stop = 1'b1;
         end else begin
            dn_take_r = 1'b1;
         end
      end else if (has_r && (rd_b_ff.distance > rd_a_ff.distance)) begin
         dn_take_r = 1'b1;
      end
      kid_sel   = dn_take_r ? kid_r : kid_l;
      child_idx = kid_sel[IDX_WIDTH-1:0];
      next_l    = idx_type'({child_idx, 1'b1});
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      bound_in       = bound_ff;
      full_in        = full_ff;
      pos_in         = pos_ff;
      cur_in         = cur_ff;
      read_idx_in    = read_idx_ff;
      acc_flag_in    = acc_flag_ff;
      entry_valid_in = entry_valid_ff;
      entry_id_in    = entry_id_ff;
      entry_dist_in  = entry_dist_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = cur_ff;
      rd_a_addr      = req_chan.read_index;
      rd_b_addr      = '0;
      dist_start     = 1'b0;
      rsp_load       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               acc_flag_in    = 1'b0;
               entry_valid_in = 1'b0;
               entry_id_in    = '0;
               entry_dist_in  = '0;
               read_idx_in    = req_chan.read_index;
               cur_in.ident   = req_chan.cand_id;
               unique case (req_chan.action)
                  ACT_START: begin
                     count_in = '0;
                     bound_in = radius_ff;
                     full_in  = 1'b0;
                     state_in = S_EMIT;
                  end
                  ACT_OFFER: begin
                     dist_start = 1'b1;
                     state_in   = S_DIST;
                  end
                  ACT_READ: begin
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_DIST: begin
            // prefetch the first compare of either sift direction
            rd_a_addr = ins_path ? parent_cnt : idx_type'(1);
            rd_b_addr = idx_type'(2);
            if (dist_done) begin
               cur_in.distance = dist_value;
               if (dist_value < bound_ff) begin
                  acc_flag_in = 1'b1;
                  if (ins_path) begin
                     pos_in   = count_ff[IDX_WIDTH-1:0];
                     state_in = S_UP;
                  end else begin
                     pos_in   = '0;
                     state_in = S_DN;
                  end
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_UP: begin
            rd_a_addr = up_up;
            wr_en     = 1'b1;
            wr_addr   = pos_ff;
            if ((pos_ff == '0) || !(rd_a_ff.distance < cur_ff.distance)) begin
               wr_data  = cur_ff;
               count_in = count_plus;
               if (count_plus >= want_eff) begin
                  bound_in = (pos_ff == '0) ? cur_ff.distance : root_dist_ff;
                  full_in  = 1'b1;
               end
               state_in = S_EMIT;
            end else begin
               // move the parent down into the hole
               wr_data = rd_a_ff;
               pos_in  = up_idx;
            end
         end
         S_DN: begin
            rd_a_addr = next_l;
            rd_b_addr = next_l + 1'b1;
            wr_en     = 1'b1;
            wr_addr   = pos_ff;
            if (dn_stop) begin
               wr_data  = cur_ff;
               bound_in = (pos_ff == '0) ? cur_ff.distance : root_dist_ff;
               state_in = S_EMIT;
            end else begin
               // move the larger son up into the hole
               wr_data = dn_take_r ? rd_b_ff : rd_a_ff;
               pos_in  = child_idx;
            end
         end
         S_READ: begin
            if (CNT_WIDTH'(read_idx_ff) < count_ff) begin
               entry_valid_in = 1'b1;
               entry_id_in    = rd_a_ff.ident;
               entry_dist_in  = rd_a_ff.distance;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         bound_ff   <= DIST_MAX;
         full_ff    <= 1'b0;
         query_x_ff <= '0;
         query_y_ff <= '0;
         query_z_ff <= '0;
         radius_ff  <= DIST_MAX;
         wanted_ff  <= cnt_type'(1);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bound_ff <= bound_in;
         full_ff  <= full_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_QUERY_X:   query_x_ff <= coord_type'(csr_wdata[COORD_WIDTH-1:0]);
               CSR_QUERY_Y:   query_y_ff <= coord_type'(csr_wdata[COORD_WIDTH-1:0]);
               CSR_QUERY_Z:   query_z_ff <= coord_type'(csr_wdata[COORD_WIDTH-1:0]);
               CSR_RADIUS_SQ: radius_ff  <= csr_wdata[DIST_WIDTH-1:0];
               CSR_WANTED:    wanted_ff  <= csr_wdata[CNT_WIDTH-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      read_idx_ff    <= read_idx_in;
      acc_flag_ff    <= acc_flag_in;
      entry_valid_ff <= entry_valid_in;
      entry_id_ff    <= entry_id_in;
      entry_dist_ff  <= entry_dist_in;
      // mirror of the root distance
      if (wr_en && (wr_addr == '0)) begin
         root_dist_ff <= wr_data.distance;
      end
   end

   // heap memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_accepted_ff    <= acc_flag_ff;
         rsp_count_ff       <= count_ff;
         rsp_bound_ff       <= bound_ff;
         rsp_entry_valid_ff <= entry_valid_ff;
         rsp_entry_id_ff    <= entry_id_ff;
         rsp_entry_dist_ff  <= entry_dist_ff;
      end
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.accepted       = rsp_accepted_ff;
   assign rsp_chan.found_count    = rsp_count_ff;
   assign rsp_chan.bound_distance = rsp_bound_ff;
   assign rsp_chan.entry_valid    = rsp_entry_valid_ff;
   assign rsp_chan.entry_id       = rsp_entry_id_ff;
   assign rsp_chan.entry_distance = rsp_entry_dist_ff;

endmodule

// ----- tb/k_nearest_max_heap_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_nearest_max_heap_core_test: self-checking bench for the k-nearest max-heap
// Drives start, offer, read and unknown items through the request channel in
// bursts, stalls the response channel, and compares every result against a
// heap tracker that recomputes distances, insertions and bounds on its own.
// ----------------------------------------------------------------------------
module k_nearest_max_heap_core_test;
   import knmh_pkg::*;

   localparam action_type ACT_UNKNOWN = 2'd3;
   localparam coord_type  COORD_MIN   = 16'sh8000;
   localparam coord_type  COORD_MAX   = 16'sh7FFF;
   localparam int STALL_LIMIT = 2000;
   localparam int ITEM_TARGET = 1650;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_pattern_type;

   typedef struct packed {
      action_type action;
      coord_type  cand_x;
      coord_type  cand_y;
      coord_type  cand_z;
      ident_type  cand_id;
      idx_type    read_index;
   } request_item_type;

   typedef struct packed {
      logic      accepted;
      cnt_type   found_count;
      dist_type  bound_distance;
      logic      entry_valid;
      ident_type entry_id;
      dist_type  entry_distance;
   } response_item_type;

   class nearest_heap_tracker;
      dist_type          slot_dist[HEAP_DEPTH];
      ident_type         slot_ident[HEAP_DEPTH];
      int                held;
      dist_type          accept_bound;
      bit                full;
      coord_type         query_x;
      coord_type         query_y;
      coord_type         query_z;
      dist_type          radius_sq;
      logic [6:0]        wanted;
      response_item_type pending_results[$];
      int                mismatch_count;
      int                result_number;

      function new();
         held           = 0;
         accept_bound   = DIST_MAX;
         full           = 1'b0;
         query_x        = '0;
         query_y        = '0;
         query_z        = '0;
         radius_sq      = DIST_MAX;
         wanted         = 7'd1;
         mismatch_count = 0;
         result_number  = 0;
      endfunction

      function void write_register(csr_idx_type idx, csr_data_type value);
         case (idx)
            CSR_QUERY_X:   query_x = coord_type'(value[COORD_WIDTH-1:0]);
            CSR_QUERY_Y:   query_y = coord_type'(value[COORD_WIDTH-1:0]);
            CSR_QUERY_Z:   query_z = coord_type'(value[COORD_WIDTH-1:0]);
            CSR_RADIUS_SQ: radius_sq = value;
            CSR_WANTED:    wanted = value[6:0];
            default: ;
         endcase
      endfunction

      function dist_type squared_distance(coord_type cx, coord_type cy, coord_type cz);
         longint dx, dy, dz, total;
         dx = longint'(cx) - longint'(query_x);
         dy = longint'(cy) - longint'(query_y);
         dz = longint'(cz) - longint'(query_z);
         total = dx * dx + dy * dy + dz * dz;
         if (total > longint'(DIST_MAX))
            return DIST_MAX;
         return dist_type'(total);
      endfunction

      function void swap_slots(int a, int b);
         dist_type  d;
         ident_type id;
         d             = slot_dist[a];
         id            = slot_ident[a];
         slot_dist[a]  = slot_dist[b];
         slot_ident[a] = slot_ident[b];
         slot_dist[b]  = d;
         slot_ident[b] = id;
      endfunction

      // move up only past a strictly smaller parent
      function void sift_up(int pos);
         int up;
         while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!(slot_dist[up] < slot_dist[pos]))
               break;
            swap_slots(up, pos);
            pos = up;
         end
      endfunction

      // right son wins only when strictly greater than the left one
      function void sift_down(int fill);
         int top, kid;
         top = 0;
         kid = 1;
         while (kid < fill) begin
            if (slot_dist[kid] <= slot_dist[top]) begin
               kid++;
               if (kid >= fill || slot_dist[kid] <= slot_dist[top])
                  return;
            end else if (kid + 1 < fill && slot_dist[kid + 1] > slot_dist[kid]) begin
               kid++;
            end
            swap_slots(top, kid);
            top = kid;
            kid = 2 * top + 1;
         end
      endfunction

      function void apply_request(request_item_type it);
         response_item_type r;
         dist_type          d;
         int                want;
         r = '0;
         case (it.action)
            ACT_START: begin
               held         = 0;
               accept_bound = radius_sq;
               full         = 1'b0;
            end
            ACT_OFFER: begin
               d = squared_distance(it.cand_x, it.cand_y, it.cand_z);
               want = (wanted == 0) ? 1 : ((wanted > HEAP_DEPTH) ? HEAP_DEPTH : int'(wanted));
               if (d < accept_bound) begin
                  r.accepted = 1'b1;
                  if (!full && held < HEAP_DEPTH) begin
                     slot_dist[held]  = d;
                     slot_ident[held] = it.cand_id;
                     sift_up(held);
                     held++;
                     if (held >= want) begin
                        accept_bound = slot_dist[0];
                        full         = 1'b1;
                     end
                  end else begin
                     slot_dist[0]  = d;
                     slot_ident[0] = it.cand_id;
                     sift_down(held);
                     accept_bound = slot_dist[0];
                  end
               end
            end
            ACT_READ: begin
               if (int'(it.read_index) < held) begin
                  r.entry_valid    = 1'b1;
                  r.entry_id       = slot_ident[it.read_index];
                  r.entry_distance = slot_dist[it.read_index];
               end
            end
            default: ;
         endcase
         r.found_count    = cnt_type'(held);
         r.bound_distance = accept_bound;
         pending_results.push_back(r);
      endfunction

      function void report_mismatch(string what, logic [63:0] got_value,
                                    logic [63:0] want_value);
         mismatch_count++;
         $display("[%0t] result %0d: %s got %0h, expected %0h", $time, result_number,
                  what, got_value, want_value);
      endfunction

      function void match_response(response_item_type got);
         response_item_type oldest;
         result_number++;
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", '0, '0);
            return;
         end
         oldest = pending_results.pop_front();
         if (got.accepted !== oldest.accepted)
            report_mismatch("accepted", 64'(got.accepted), 64'(oldest.accepted));
         if (got.found_count !== oldest.found_count)
            report_mismatch("found_count", 64'(got.found_count), 64'(oldest.found_count));
         if (got.bound_distance !== oldest.bound_distance)
            report_mismatch("bound_distance", 64'(got.bound_distance),
                            64'(oldest.bound_distance));
         if (got.entry_valid !== oldest.entry_valid)
            report_mismatch("entry_valid", 64'(got.entry_valid), 64'(oldest.entry_valid));
         if (got.entry_id !== oldest.entry_id)
            report_mismatch("entry_id", 64'(got.entry_id), 64'(oldest.entry_id));
         if (got.entry_distance !== oldest.entry_distance)
            report_mismatch("entry_distance", 64'(got.entry_distance),
                            64'(oldest.entry_distance));
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         csr_we;
   csr_idx_type  csr_index;
   csr_data_type csr_wdata;

   knmh_req_if req_bus();
   knmh_rsp_if rsp_bus();

   nearest_heap_tracker heap_track;
   rx_pattern_type      ready_mode = RX_OPEN;
   int burst_left  = 0;
   int items_sent  = 0;
   int idle_cycles = 0;
   int cycle_count = 0;
   int stall_left  = 0;

   k_nearest_max_heap_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic issue(action_type act, coord_type x, coord_type y, coord_type z,
                        ident_type id, idx_type slot);
      request_item_type it;
      int               gap;
      it = '{act, x, y, z, id, slot};
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.cand_x     <= x;
      req_bus.cand_y     <= y;
      req_bus.cand_z     <= z;
      req_bus.cand_id    <= id;
      req_bus.read_index <= slot;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      heap_track.apply_request(it);
      burst_left--;
      items_sent++;
   endtask

   // hold the sender until every pending result has drained
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (heap_track.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, csr_data_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      heap_track.write_register(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(coord_type qx, coord_type qy, coord_type qz, dist_type radius,
                            logic [6:0] wanted);
      write_reg(CSR_QUERY_X, {{(DIST_WIDTH-COORD_WIDTH){1'b0}}, qx});
      write_reg(CSR_QUERY_Y, {{(DIST_WIDTH-COORD_WIDTH){1'b0}}, qy});
      write_reg(CSR_QUERY_Z, {{(DIST_WIDTH-COORD_WIDTH){1'b0}}, qz});
      write_reg(CSR_RADIUS_SQ, radius);
      write_reg(CSR_WANTED, {{(DIST_WIDTH-7){1'b0}}, wanted});
   endtask

   function automatic coord_type near_point(coord_type q, int spread);
      if (spread == 0)
         return coord_type'(int'(q) + 256 * (int'($urandom_range(0, 2)) - 1));
      if (spread >= 32767)
         return coord_type'($urandom);
      return coord_type'(int'(q) + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // response side: check, then pick the next ready level
   always @(posedge clock) begin
      response_item_type got;
      cycle_count++;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = '{rsp_bus.accepted, rsp_bus.found_count, rsp_bus.bound_distance,
                 rsp_bus.entry_valid, rsp_bus.entry_id, rsp_bus.entry_distance};
         heap_track.match_response(got);
      end
      if (cycle_count % 256 == 0)
         ready_mode = rx_pattern_type'($urandom_range(0, 3));
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (ready_mode)
            RX_OPEN:  rsp_bus.ready <= 1'b1;
            RX_LIGHT: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  stall_left = $urandom_range(4, 24);
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      coord_type  qx, qy, qz, px, py, pz;
      dist_type   radius;
      logic [6:0] wanted;
      int         spread, pick, n, want_eff, s;

      clock              = 1'b0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_START;
      req_bus.cand_x     = '0;
      req_bus.cand_y     = '0;
      req_bus.cand_z     = '0;
      req_bus.cand_id    = '0;
      req_bus.read_index = '0;
      rsp_bus.ready      = 1'b0;
      heap_track         = new();
      px = '0;
      py = '0;
      pz = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // offers before any start begin from the reset state: an empty heap and the all-ones bound
      issue(ACT_OFFER, 16'sd256, 16'sd0, 16'sd0, 16'h0001, '0);
      issue(ACT_OFFER, COORD_MIN, COORD_MIN, COORD_MIN, 16'hFFFF, '0);
      issue(ACT_OFFER, 16'sd0, 16'sd0, 16'sd0, 16'hA5A5, '0);
      issue(ACT_READ, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 6'd0);
      issue(ACT_READ, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 6'd63);
      issue(ACT_UNKNOWN, -16'sd1, -16'sd1, -16'sd1, 16'hFFFF, 6'd63);
      issue(ACT_START, 16'sd0, 16'sd0, 16'sd0, 16'h0000, '0);
      settle();

      // query at the corner, farthest candidate at the opposite corner
      configure(COORD_MAX, COORD_MIN, COORD_MAX, DIST_MAX, 7'd4);
      issue(ACT_START, 16'sd0, 16'sd0, 16'sd0, 16'h0000, '0);
      issue(ACT_OFFER, COORD_MIN, COORD_MAX, COORD_MIN, 16'h0000, '0);
      issue(ACT_OFFER, COORD_MAX, COORD_MIN, COORD_MAX, 16'h0001, '0);
      settle();
      // zero wanted acts as one: the next insertion fills the heap
      write_reg(CSR_WANTED, '0);
      issue(ACT_OFFER, 16'sd32511, COORD_MIN, COORD_MAX, 16'h0002, '0);
      issue(ACT_OFFER, COORD_MAX, -16'sd32512, COORD_MAX, 16'h0003, '0);
      issue(ACT_OFFER, COORD_MAX, COORD_MIN, 16'sd32511, 16'h0004, '0);
      for (int i = 0; i < 4; i++)
         issue(ACT_READ, 16'sd0, 16'sd0, 16'sd0, 16'h0000, idx_type'(i));
      settle();

      // zero radius rejects even an exact hit; wanted above depth clamps
      configure(16'sd0, 16'sd0, 16'sd0, '0, 7'd100);
      issue(ACT_START, 16'sd0, 16'sd0, 16'sd0, 16'h0000, '0);
      issue(ACT_OFFER, 16'sd0, 16'sd0, 16'sd0, 16'h5A5A, '0);
      issue(ACT_READ, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 6'd0);

      while (items_sent < ITEM_TARGET) begin
         settle();
         pick = $urandom_range(0, 9);
         spread = (pick < 2) ? 0 : (pick < 6) ? 255 : (pick < 8) ? 4095 :
                  (pick < 9) ? 32767 : 1023;
         if (heap_track.held > 1 && $urandom_range(0, 4) == 0) begin
            // keep the query running with a new wanted count of at most the held count
            write_reg(CSR_WANTED, csr_data_type'($urandom_range(0, heap_track.held)));
         end else begin
            if ($urandom_range(0, 7) == 0) begin
               qx = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
               qy = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
               qz = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            end else begin
               qx = coord_type'($urandom);
               qy = coord_type'($urandom);
               qz = coord_type'($urandom);
            end
            pick = $urandom_range(0, 9);
            s = (spread < 256) ? 256 : spread;
            if (pick < 6)
               radius = DIST_MAX;
            else if (pick < 8 && spread < 32767)
               radius = dist_type'($urandom_range(0, 3 * s * s));
            else if (pick < 9)
               radius = dist_type'({$urandom, $urandom});
            else
               radius = dist_type'($urandom_range(0, 1000));
            pick = $urandom_range(0, 9);
            wanted = (pick < 6) ? 7'($urandom_range(1, 12)) :
                     (pick < 8) ? 7'($urandom_range(13, 64)) :
                     (pick < 9) ? 7'd0 : 7'($urandom_range(65, 127));
            configure(qx, qy, qz, radius, wanted);
            issue(ACT_START, coord_type'($urandom), coord_type'($urandom),
                  coord_type'($urandom), ident_type'($urandom), idx_type'($urandom));
         end
         wanted   = heap_track.wanted;
         want_eff = (wanted == 0) ? 1 : (wanted > HEAP_DEPTH) ? HEAP_DEPTH : int'(wanted);
         n = $urandom_range(10, 60) + ((want_eff > 12) ? want_eff : 0);
         for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // reuse the last point now and then for equal distances
               if ($urandom_range(0, 7) != 0) begin
                  px = near_point(heap_track.query_x, spread);
                  py = near_point(heap_track.query_y, spread);
                  pz = near_point(heap_track.query_z, spread);
               end
               issue(ACT_OFFER, px, py, pz, ident_type'($urandom), idx_type'($urandom));
            end else if (pick < 88) begin
               issue(ACT_READ, coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), ident_type'($urandom),
                     (heap_track.held > 0 && $urandom_range(0, 4) != 0)
                        ? idx_type'($urandom_range(0, heap_track.held - 1))
                        : idx_type'($urandom));
            end else begin
               issue((pick < 95) ? ACT_UNKNOWN : ACT_START, coord_type'($urandom),
                     coord_type'($urandom), coord_type'($urandom),
                     ident_type'($urandom), idx_type'($urandom));
            end
         end
         // walk the whole heap now and then
         if ($urandom_range(0, 2) == 0)
            for (int i = 0; i < heap_track.held; i++)
               issue(ACT_READ, 16'sd0, 16'sd0, 16'sd0, 16'h0000, idx_type'(i));
      end

      settle();
      repeat (20) @(posedge clock);
      if (heap_track.mismatch_count == 0 && heap_track.pending_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
